// ----- rtl/core/vrba_pkg.sv -----
// Package for the volume ring block allocator.
// Holds widths, register indexes, codes, controller states and command/status structs.
// No dependencies.
`default_nettype none

package vrba_pkg;

	// Default ring depth
	localparam int MAX_VOLUMES_DEF = 16;

	// Field widths
	localparam int GEN_W      = 32;
	localparam int BLK_W      = 32;
	localparam int ADDR_W     = GEN_W + BLK_W;
	localparam int VIX_W      = 4;
	localparam int CNT_W      = 5;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int ENTRY_W    = GEN_W + BLK_W;

	// Output tdata: logic_address, volume_index, block_index, padded to bytes
	localparam int OUT_USED_W  = ADDR_W + VIX_W + BLK_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME_COUNT    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME_CAPACITY = 8'd1;

	// Configuration reset values
	localparam logic [CNT_W-1:0] VOLUME_COUNT_RST    = 5'd4;
	localparam logic [BLK_W-1:0] VOLUME_CAPACITY_RST = 32'd1024;

	// Request kinds
	localparam logic ACT_APPEND = 1'b0;
	localparam logic ACT_CHECK  = 1'b1;

	// Result status codes
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_UNAVAIL = 1'b1;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK_MOD,
		S_CHK_RD,
		S_CHK_EVAL,
		S_APP_RD,
		S_APP_EVAL,
		S_MV_MOD,
		S_MV_RD,
		S_MV_EVAL
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic ready;        // input side may take a transaction
		logic accept;       // capture the query address
		logic mod_start;    // launch the serial modulo
		logic mod_sel_next; // modulo operand: 1 = current volume + 1, 0 = query generation
		logic addr_ld_cur;  // table address <= current volume
		logic addr_ld_rem;  // table address <= modulo remainder
		logic app_commit;   // finish an append in place
		logic move_commit;  // finish an append after moving to the next volume
		logic chk_commit;   // finish a check
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mod_busy;
		logic app_full;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/vrba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vrba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire                                         clk,
	input  wire                                         we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                            wdata,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/vrba_mod.sv -----
// Bit-serial remainder unit: 32-bit dividend modulo a 5-bit divisor, one bit per cycle.
// Depends on vrba_pkg.
`default_nettype none

module vrba_mod (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [vrba_pkg::GEN_W-1:0]  dividend,
	input  wire  [vrba_pkg::CNT_W-1:0]  divisor,
	output logic                        busy,
	output logic [vrba_pkg::CNT_W-1:0]  rem
);

	localparam int STEP_W = $clog2(vrba_pkg::GEN_W) + 1;

	logic [vrba_pkg::GEN_W-1:0] div_q;
	logic [vrba_pkg::CNT_W-1:0] dsr_q;
	logic [vrba_pkg::CNT_W-1:0] rem_q;
	logic [STEP_W-1:0]          cnt_q;
	logic [vrba_pkg::CNT_W:0]   trial;

	// Shift in the next dividend bit
	assign trial = {rem_q, div_q[vrba_pkg::GEN_W-1]};

	// Control: remaining step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEP_W'(vrba_pkg::GEN_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - STEP_W'(1);
		end
	end

	// Restoring remainder step
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			div_q <= {div_q[vrba_pkg::GEN_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= vrba_pkg::CNT_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= vrba_pkg::CNT_W'(trial);
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/core/vrba_dp.sv -----
// Datapath: configuration registers, volume table, current volume, modulo unit, result register.
// Depends on vrba_pkg, vrba_ram, vrba_mod.
`default_nettype none

module vrba_dp #(
	parameter int MAX_VOLUMES = vrba_pkg::MAX_VOLUMES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration
	input  wire                              cfg_valid,
	input  wire  [vrba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [vrba_pkg::CFG_DATA_W-1:0]  cfg_data,
	// request payload
	input  wire  [vrba_pkg::ADDR_W-1:0]      in_addr,
	// control
	input  wire vrba_pkg::cmd_t              cmd,
	output vrba_pkg::sts_t                   sts,
	// result
	input  wire                              out_ready,
	output logic                             out_valid,
	output logic                             out_status,
	output logic [vrba_pkg::ADDR_W-1:0]      out_addr,
	output logic [vrba_pkg::VIX_W-1:0]       out_vix,
	output logic [vrba_pkg::BLK_W-1:0]       out_blk
);

	localparam int VOL_W = (MAX_VOLUMES > 1) ? $clog2(MAX_VOLUMES) : 1;

	logic [vrba_pkg::CNT_W-1:0]   count_q;
	logic [vrba_pkg::BLK_W-1:0]   cap_q;
	logic [vrba_pkg::CNT_W-1:0]   ring_n;
	logic [vrba_pkg::ADDR_W-1:0]  qaddr_q;
	logic [VOL_W-1:0]             cur_q;
	logic [vrba_pkg::GEN_W-1:0]   curgen_q;
	logic [VOL_W-1:0]             addr_q;
	logic [MAX_VOLUMES-1:0]       valid_q;
	logic [vrba_pkg::ENTRY_W-1:0] rd_data;
	logic [vrba_pkg::ENTRY_W-1:0] wr_data;
	logic                         wr_en;
	logic [vrba_pkg::GEN_W-1:0]   ent_gen;
	logic [vrba_pkg::BLK_W-1:0]   ent_fill;
	logic [vrba_pkg::GEN_W-1:0]   gen_new;
	logic [vrba_pkg::GEN_W-1:0]   mod_dividend;
	logic                         mod_busy;
	logic [vrba_pkg::CNT_W-1:0]   mod_rem;
	logic                         chk_ok;
	logic                         cap_zero;
	logic                         out_free;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= vrba_pkg::VOLUME_COUNT_RST;
			cap_q   <= vrba_pkg::VOLUME_CAPACITY_RST;
		end else if (cfg_valid) begin
			if (cfg_index == vrba_pkg::REG_VOLUME_COUNT) begin
				count_q <= cfg_data[vrba_pkg::CNT_W-1:0];
			end else if (cfg_index == vrba_pkg::REG_VOLUME_CAPACITY) begin
				cap_q <= cfg_data[vrba_pkg::BLK_W-1:0];
			end
		end
	end

	// Effective ring size, clamped to 1..MAX_VOLUMES
	always_comb begin
		if (count_q == '0) begin
			ring_n = vrba_pkg::CNT_W'(1);
		end else if (32'(count_q) > 32'(MAX_VOLUMES)) begin
			ring_n = vrba_pkg::CNT_W'(MAX_VOLUMES);
		end else begin
			ring_n = count_q;
		end
	end

	// Serial modulo, shared by address check and ring advance
	assign mod_dividend = cmd.mod_sel_next ? (vrba_pkg::GEN_W'(cur_q) + vrba_pkg::GEN_W'(1))
	                                       : in_addr[vrba_pkg::ADDR_W-1:vrba_pkg::BLK_W];

	vrba_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (mod_dividend),
		.divisor  (ring_n),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

	// Query capture and table address
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			qaddr_q <= in_addr;
		end
		if (cmd.addr_ld_cur) begin
			addr_q <= cur_q;
		end else if (cmd.addr_ld_rem) begin
			addr_q <= VOL_W'(mod_rem);
		end
	end

	// Volume table: {generation, fill} per volume
	vrba_ram #(
		.WIDTH (vrba_pkg::ENTRY_W),
		.DEPTH (MAX_VOLUMES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_q),
		.wdata (wr_data),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	// Entries never written read as their reset value
	always_comb begin
		if (valid_q[addr_q]) begin
			ent_gen  = rd_data[vrba_pkg::ENTRY_W-1:vrba_pkg::BLK_W];
			ent_fill = rd_data[vrba_pkg::BLK_W-1:0];
		end else begin
			ent_gen  = vrba_pkg::GEN_W'(addr_q);
			ent_fill = '0;
		end
	end

	// Moving on: a used volume starts a new generation
	assign gen_new  = (ent_fill != '0) ? (ent_gen + vrba_pkg::GEN_W'(ring_n)) : ent_gen;
	assign cap_zero = (cap_q == '0);
	assign chk_ok   = (ent_gen == qaddr_q[vrba_pkg::ADDR_W-1:vrba_pkg::BLK_W]) &&
	                  (qaddr_q[vrba_pkg::BLK_W-1:0] < ent_fill);

	// Table write
	assign wr_en = cmd.app_commit || cmd.move_commit;
	always_comb begin
		if (cmd.move_commit) begin
			wr_data = {gen_new, (cap_zero ? vrba_pkg::BLK_W'(0) : vrba_pkg::BLK_W'(1))};
		end else begin
			wr_data = {ent_gen, ent_fill + vrba_pkg::BLK_W'(1)};
		end
	end

	// Written-entry flags and current volume
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			cur_q    <= '0;
			curgen_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[addr_q] <= 1'b1;
			end
			if (cmd.move_commit) begin
				cur_q    <= addr_q;
				curgen_q <= gen_new;
			end
		end
	end

	// Result register
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.app_commit || cmd.move_commit || cmd.chk_commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.app_commit) begin
			out_status <= vrba_pkg::ST_OK;
			out_addr   <= {curgen_q, ent_fill};
			out_vix    <= vrba_pkg::VIX_W'(cur_q);
			out_blk    <= ent_fill;
		end else if (cmd.move_commit) begin
			out_status <= cap_zero ? vrba_pkg::ST_UNAVAIL : vrba_pkg::ST_OK;
			out_addr   <= cap_zero ? vrba_pkg::ADDR_W'(0) : {gen_new, vrba_pkg::BLK_W'(0)};
			out_vix    <= vrba_pkg::VIX_W'(addr_q);
			out_blk    <= '0;
		end else if (cmd.chk_commit) begin
			out_status <= chk_ok ? vrba_pkg::ST_OK : vrba_pkg::ST_UNAVAIL;
			out_addr   <= qaddr_q;
			out_vix    <= vrba_pkg::VIX_W'(addr_q);
			out_blk    <= qaddr_q[vrba_pkg::BLK_W-1:0];
		end
	end

	// Status to controller
	assign sts.mod_busy = mod_busy;
	assign sts.app_full = (ent_fill >= cap_q);
	assign sts.out_free = out_free;

endmodule

`default_nettype wire

// ----- rtl/core/vrba_ctrl.sv -----
// Controller state machine: sequences append, ring advance and address check.
// Depends on vrba_pkg.
`default_nettype none

module vrba_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  in_action,
	input  wire vrba_pkg::sts_t  sts,
	output vrba_pkg::cmd_t       cmd
);

	vrba_pkg::state_t state_q;
	vrba_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vrba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vrba_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = (in_action == vrba_pkg::ACT_CHECK) ? vrba_pkg::S_CHK_MOD
					                                             : vrba_pkg::S_APP_RD;
				end
			end
			vrba_pkg::S_CHK_MOD: begin
				if (!sts.mod_busy) begin
					state_d = vrba_pkg::S_CHK_RD;
				end
			end
			vrba_pkg::S_CHK_RD:  state_d = vrba_pkg::S_CHK_EVAL;
			vrba_pkg::S_CHK_EVAL: begin
				if (sts.out_free) begin
					state_d = vrba_pkg::S_IDLE;
				end
			end
			vrba_pkg::S_APP_RD:  state_d = vrba_pkg::S_APP_EVAL;
			vrba_pkg::S_APP_EVAL: begin
				if (sts.app_full) begin
					state_d = vrba_pkg::S_MV_MOD;
				end else if (sts.out_free) begin
					state_d = vrba_pkg::S_IDLE;
				end
			end
			vrba_pkg::S_MV_MOD: begin
				if (!sts.mod_busy) begin
					state_d = vrba_pkg::S_MV_RD;
				end
			end
			vrba_pkg::S_MV_RD:   state_d = vrba_pkg::S_MV_EVAL;
			vrba_pkg::S_MV_EVAL: begin
				if (sts.out_free) begin
					state_d = vrba_pkg::S_IDLE;
				end
			end
			default:             state_d = vrba_pkg::S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		case (state_q)
			vrba_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_action == vrba_pkg::ACT_CHECK) begin
						cmd.mod_start = 1'b1;
					end else begin
						cmd.addr_ld_cur = 1'b1;
					end
				end
			end
			vrba_pkg::S_CHK_MOD, vrba_pkg::S_MV_MOD: begin
				cmd.addr_ld_rem = !sts.mod_busy;
			end
			vrba_pkg::S_CHK_EVAL: begin
				cmd.chk_commit = sts.out_free;
			end
			vrba_pkg::S_APP_EVAL: begin
				if (sts.app_full) begin
					cmd.mod_start    = 1'b1;
					cmd.mod_sel_next = 1'b1;
				end else begin
					cmd.app_commit = sts.out_free;
				end
			end
			vrba_pkg::S_MV_EVAL: begin
				cmd.move_commit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/volume_ring_block_allocator.sv -----
// Volume ring block allocator, top level. One request at a time; a result register
// frees the input side while a result waits. An append reads the table and stores its
// result; an append that moves to the next volume and a check also run the 32-step serial
// modulo, which sets the long cases. The next request is taken the cycle after a result is stored.
// Reset (arst_n, async, low): volume count 4, capacity 1024, current volume and generation 0,
// every table entry reads generation = index, fill = 0 until first written. No clearing pass.
// Depends on vrba_pkg, vrba_ctrl, vrba_dp.
`default_nettype none

module volume_ring_block_allocator #(
	parameter int MAX_VOLUMES = vrba_pkg::MAX_VOLUMES_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// configuration write channel
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [vrba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [vrba_pkg::CFG_DATA_W-1:0]    cfg_data,
	// request stream
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [vrba_pkg::ADDR_W-1:0]        s_tdata,  // [63:0] query_address
	input  wire                                s_tuser,  // [0] action
	// result stream
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [vrba_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [63:0] logic_address,
	                                                     // [67:64] volume_index,
	                                                     // [99:68] block_index, rest zero
	output logic                               m_tuser   // [0] status
);

	vrba_pkg::cmd_t cmd;
	vrba_pkg::sts_t sts;

	logic [vrba_pkg::ADDR_W-1:0] out_addr;
	logic [vrba_pkg::VIX_W-1:0]  out_vix;
	logic [vrba_pkg::BLK_W-1:0]  out_blk;

	vrba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (s_tuser),
		.sts       (sts),
		.cmd       (cmd)
	);

	vrba_dp #(
		.MAX_VOLUMES (MAX_VOLUMES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_addr    (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (m_tuser),
		.out_addr   (out_addr),
		.out_vix    (out_vix),
		.out_blk    (out_blk)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = cmd.ready;
	assign m_tdata   = {{(vrba_pkg::OUT_TDATA_W - vrba_pkg::OUT_USED_W){1'b0}},
	                    out_blk, out_vix, out_addr};

	// After a transaction is taken the block is busy in the cycle after
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request side ready right after a transaction");

	// The modulo unit is never relaunched while it runs
	a_mod_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_start |-> !sts.mod_busy)
		else $error("modulo restarted while busy");

	// At most one result is stored per cycle
	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.app_commit, cmd.move_commit, cmd.chk_commit}))
		else $error("more than one result stored in a cycle");

	// A result is stored only when the result register can take it
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.app_commit || cmd.move_commit || cmd.chk_commit) |-> (!m_tvalid || m_tready))
		else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
